@@ rtl/lcdww_pkg.sv @@
package lcdww_pkg;

	// word buffer depth (longest word kept, later characters dropped)
	localparam int MAX_WORD = 32;
	localparam int IDX_W    = $clog2(MAX_WORD);
	localparam int WL_W     = $clog2(MAX_WORD + 1);

	// field and register widths
	localparam int CHAR_W   = 8;
	localparam int LW_W     = 6;
	localparam int LC_W     = 2;
	localparam int BASE_W   = 7;
	localparam int CFG_W    = 7;
	localparam int CFG_IX_W = 2;

	// shared adder operands: column counter width, sum one bit wider
	localparam int OPND_W = 6;
	localparam int SUM_W  = OPND_W + 1;
	localparam logic [OPND_W-1:0] COL_MAX = {OPND_W{1'b1}};

	// display codes
	localparam logic [CHAR_W-1:0] CMD_CLEAR  = 8'h01;
	localparam logic              CMD_DDRAM  = 1'b1;
	localparam logic [CHAR_W-1:0] SPACE_CODE = 8'h20;

	localparam logic ACT_START = 1'b0;
	localparam logic RS_INSTR  = 1'b0;
	localparam logic RS_DATA   = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IX_W-1:0] REG_LINE_WIDTH = 2'd0;
	localparam logic [CFG_IX_W-1:0] REG_LINE_COUNT = 2'd1;
	localparam logic [CFG_IX_W-1:0] REG_ROW2_BASE  = 2'd2;

	typedef struct packed {
		logic [OPND_W-1:0] a;
		logic [OPND_W-1:0] b;
		logic              cin;
		logic [OPND_W-1:0] limit;
	} alu_req_t;

	typedef struct packed {
		logic [SUM_W-1:0]  sum;
		logic              gt;
		logic              eq;
		logic [OPND_W-1:0] sat;
	} alu_rsp_t;

endpackage

@@ rtl/lcdww_ram.sv @@
module lcdww_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/lcdww_alu.sv @@
module lcdww_alu (
	input  lcdww_pkg::alu_req_t req,
	output lcdww_pkg::alu_rsp_t rsp
);

	import lcdww_pkg::*;

	logic [SUM_W-1:0] sum;

	// add with carry in, then compare against limit and clamp to column range
	always_comb begin
		sum     = {1'b0, req.a} + {1'b0, req.b} + SUM_W'(req.cin);
		rsp.sum = sum;
		rsp.gt  = sum > {1'b0, req.limit};
		rsp.eq  = sum == {1'b0, req.limit};
		rsp.sat = (sum > {1'b0, COL_MAX}) ? COL_MAX : sum[OPND_W-1:0];
	end

endmodule

@@ rtl/lcd_word_wrap_text_writer_unit.sv @@
// Channel   Handshake               Payload
// -------   ---------------------   ---------------------------------------------
// in        in_valid / in_ready     action, start_row, clear_first, char_code,
//                                   last_char
// out       out_valid / out_ready   reg_select, out_byte, last_of_run,
//                                   word_truncated
// cfg       cfg_we (no wait)        cfg_index, cfg_data
//
// Start item: accept cycle, then one result per cycle (optional clear, cursor) while out_ready allows.
// Character with no flush: taken in its accept cycle, no result.
// Word flush of n chars: accept, a check state, optional wrap cursor, n chars
// and a space, one per cycle while out_ready allows, paced by the single adder and
// the one read port of the word store. in_ready is low until the last item is loaded.
// Reset clears control state and loads register defaults; word store not cleared.
// A stalled out_ready holds the sequencer; results are neither lost nor repeated.
module lcd_word_wrap_text_writer_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	// input channel
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                action,
	input  logic                                start_row,
	input  logic                                clear_first,
	input  logic [lcdww_pkg::CHAR_W-1:0]        char_code,
	input  logic                                last_char,
	// output channel
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                reg_select,
	output logic [lcdww_pkg::CHAR_W-1:0]        out_byte,
	output logic                                last_of_run,
	output logic                                word_truncated,
	// configuration
	input  logic                                cfg_we,
	input  logic [lcdww_pkg::CFG_IX_W-1:0]      cfg_index,
	input  logic [lcdww_pkg::CFG_W-1:0]         cfg_data
);

	import lcdww_pkg::*;

	// sequencer states
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_CLEAR  = 3'd1; // clear instruction of a start item
	localparam logic [2:0] ST_CURSOR = 3'd2; // cursor of a start item, ends run
	localparam logic [2:0] ST_CHECK  = 3'd3; // fit test, first word store read
	localparam logic [2:0] ST_WRAP   = 3'd4; // cursor to row two on a wrap
	localparam logic [2:0] ST_CHAR   = 3'd5; // one buffered char per cycle while out_ready allows
	localparam logic [2:0] ST_SPACE  = 3'd6; // trailing space, ends run

	logic [2:0]        state_q;
	logic [LW_W-1:0]   line_width_q;
	logic [LC_W-1:0]   line_count_q;
	logic [BASE_W-1:0] row2_base_q;
	logic [OPND_W-1:0] col_q;
	logic              row_q;
	logic [WL_W-1:0]   wl_q;
	logic              ovf_q;
	logic              trunc_q;
	logic [IDX_W-1:0]  idx_q;

	logic              out_valid_q;
	logic              rs_q;
	logic [CHAR_W-1:0] byte_q;
	logic              last_q;
	logic              otr_q;

	logic              accept;
	logic              slot_free;
	logic              emit;
	logic              is_space;
	logic              store;
	logic              flush;
	logic              rows_two;
	logic              ram_re;
	logic [IDX_W-1:0]  ram_raddr;
	logic [CHAR_W-1:0] ram_rdata;
	logic              rs_d;
	logic [CHAR_W-1:0] byte_d;
	logic              last_d;
	alu_req_t          alu_req;
	alu_rsp_t          alu_rsp;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign emit      = slot_free && (state_q != ST_IDLE) && (state_q != ST_CHECK);
	assign rows_two  = line_count_q[1]; // 0 acts as 1, 3 acts as 2

	assign is_space  = (char_code == SPACE_CODE);
	assign store     = !is_space && (wl_q < WL_W'(MAX_WORD));
	assign flush     = (is_space || last_char) && ((wl_q != '0) || store);

	// word store: one write per stored character, one read per emitted char
	lcdww_ram #(
		.WIDTH(CHAR_W),
		.DEPTH(MAX_WORD)
	) u_word_store (
		.clk  (clk),
		.we   (accept && (action != ACT_START) && store),
		.waddr(wl_q[IDX_W-1:0]),
		.wdata(char_code),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// shared adder: fit test, char index step, column update
	always_comb begin
		alu_req.a     = col_q;
		alu_req.b     = OPND_W'(wl_q);
		alu_req.cin   = 1'b0;
		alu_req.limit = line_width_q;
		unique case (state_q)
			ST_CHAR: begin
				alu_req.a     = OPND_W'(idx_q);
				alu_req.b     = '0;
				alu_req.cin   = 1'b1;
				alu_req.limit = OPND_W'(wl_q);
			end
			ST_SPACE: begin
				alu_req.cin = 1'b1;
			end
			default: begin
			end
		endcase
	end

	lcdww_alu u_alu (
		.req(alu_req),
		.rsp(alu_rsp)
	);

	// read ahead: next char is fetched as the current one is loaded
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = '0;
		if (state_q == ST_CHECK) begin
			ram_re = 1'b1;
		end else if ((state_q == ST_CHAR) && emit && !alu_rsp.eq) begin
			ram_re    = 1'b1;
			ram_raddr = alu_rsp.sum[IDX_W-1:0];
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= LW_W'(16);
			line_count_q <= LC_W'(2);
			row2_base_q  <= BASE_W'(64);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LINE_WIDTH: line_width_q <= cfg_data[LW_W-1:0];
				REG_LINE_COUNT: line_count_q <= cfg_data[LC_W-1:0];
				REG_ROW2_BASE:  row2_base_q  <= cfg_data[BASE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			col_q   <= '0;
			row_q   <= 1'b0;
			wl_q    <= '0;
			ovf_q   <= 1'b0;
			trunc_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (action == ACT_START) begin
							// pending word and its flag are dropped
							row_q   <= start_row;
							col_q   <= '0;
							wl_q    <= '0;
							ovf_q   <= 1'b0;
							trunc_q <= 1'b0;
							state_q <= clear_first ? ST_CLEAR : ST_CURSOR;
						end else begin
							if (store) begin
								wl_q <= wl_q + WL_W'(1);
							end else if (!is_space) begin
								ovf_q <= 1'b1;
							end
							if (flush) begin
								trunc_q <= ovf_q || (!is_space && !store);
								state_q <= ST_CHECK;
							end
						end
					end
				end
				ST_CLEAR: begin
					if (emit) begin
						state_q <= ST_CURSOR;
					end
				end
				ST_CURSOR: begin
					if (emit) begin
						state_q <= ST_IDLE;
					end
				end
				ST_CHECK: begin
					idx_q <= '0;
					if (alu_rsp.gt) begin
						col_q <= '0;
					end
					// last row: only the column restarts
					if (alu_rsp.gt && !row_q && rows_two) begin
						row_q   <= 1'b1;
						state_q <= ST_WRAP;
					end else begin
						state_q <= ST_CHAR;
					end
				end
				ST_WRAP: begin
					if (emit) begin
						state_q <= ST_CHAR;
					end
				end
				ST_CHAR: begin
					if (emit) begin
						idx_q <= alu_rsp.sum[IDX_W-1:0];
						if (alu_rsp.eq) begin
							state_q <= ST_SPACE;
						end
					end
				end
				ST_SPACE: begin
					if (emit) begin
						col_q   <= alu_rsp.sat;
						wl_q    <= '0;
						ovf_q   <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result of the current state; cursor instruction unless overridden
	always_comb begin
		rs_d   = RS_INSTR;
		byte_d = {CMD_DDRAM, (row_q ? row2_base_q : BASE_W'(0))};
		last_d = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				byte_d = CMD_CLEAR;
			end
			ST_CURSOR: begin
				last_d = 1'b1;
			end
			ST_CHAR: begin
				rs_d   = RS_DATA;
				byte_d = ram_rdata;
			end
			ST_SPACE: begin
				rs_d   = RS_DATA;
				byte_d = SPACE_CODE;
				last_d = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			rs_q   <= rs_d;
			byte_q <= byte_d;
			last_q <= last_d;
			otr_q  <= trunc_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign reg_select     = rs_q;
	assign out_byte       = byte_q;
	assign last_of_run    = last_q;
	assign word_truncated = otr_q;

	// checks
	a_wl_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wl_q <= WL_W'(MAX_WORD))
		else $error("word length beyond buffer depth");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=>
			(out_valid_q && $stable({rs_q, byte_q, last_q, otr_q})))
		else $error("waiting result changed before it was taken");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHAR) |-> (WL_W'(idx_q) < wl_q))
		else $error("char index past word end");

	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (action == ACT_START)) |=> ((wl_q == '0) && (col_q == '0)))
		else $error("start item left word or column state");

endmodule
